FILE: rtl/assert_macros.svh
// Assertion helpers used by psa_dpath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds whenever trig holds, in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check that cond holds in the cycle after trig.
`define ASSERT_NXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

FILE: rtl/psa_pkg.sv
package psa_pkg;

    // Pool geometry
    localparam int NPAGES       = 4096;
    localparam int PAGE_W       = 12;
    localparam int LINK_W       = 13;
    localparam int CLASSES      = 128;
    localparam int CNT_W        = 7;
    localparam int LEN_W        = 8;
    localparam int INFO_W       = 8;
    localparam int LIMIT_W      = 13;
    localparam int REGION_PAGES = CLASSES - 1;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NPAGES);

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_UNMAPPED  = 2'd2,
        ST_BAD_COUNT = 2'd3
    } status_t;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR_OOM,
        OP_ERR_UNMAPPED,
        OP_ERR_COUNT,
        OP_RES_LOOKUP,
        OP_RES_MAP,
        OP_POP_FIN,
        OP_FR_INIT,
        OP_RD_OWN_PREV,
        OP_RD_OWN_NEXT,
        OP_RD_LEN_Q,
        OP_UL_RD,
        OP_UL_WR,
        OP_UL_WR_BK,
        OP_UL_WR_FW,
        OP_FR_FIN,
        OP_PU_WR1,
        OP_PU_WR2,
        OP_MAP,
        OP_SCAN_INIT,
        OP_SCAN_NEXT,
        OP_TAKE,
        OP_SPLIT,
        OP_CUT,
        OP_FRESH,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_FR_CHK, S_LK_RD, S_LK_RES,
        S_BK0, S_BK1, S_BK2, S_BK3,
        S_FW0, S_FW1, S_FW2, S_FW3,
        S_FR_FIN, S_PU0, S_PU1, S_PU2, S_MAP, S_RES, S_RESCAN,
        S_SCAN, S_TAKE, S_TAKE_UL, S_POP_FIN, S_SPLIT, S_CUT, S_FRESH, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CTX_FREE,
        CTX_SPLIT,
        CTX_FRESH
    } ctx_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  cnt_zero;
        logic  pid_mapped;
        logic  own_match;
        logic  in_use;
        logic  len_match;
        logic  bk_ok;
        logic  fw_ok;
        logic  merge_ok;
        logic  scan_hit;
        logic  scan_last;
        logic  exact;
        logic  fresh_ok;
        logic  map_last;
        logic  out_free;
    } stat_t;

endpackage

FILE: rtl/psa_ctrl.sv
module psa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  psa_pkg::stat_t stat,
    output psa_pkg::cmd_t  cmd
);
    import psa_pkg::*;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;

    // State and context registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ctx_reg   <= CTX_FREE;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

    // Sequence the micro-operations
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        cmd.op     = OP_NONE;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.func)
                    FUNC_ALLOC:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.op     = OP_ERR_COUNT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_SCAN_INIT;
                            state_next = S_SCAN;
                        end
                    end
                    FUNC_FREE, FUNC_LOOKUP:
                    begin
                        if (!stat.pid_mapped)
                        begin
                            cmd.op     = OP_ERR_UNMAPPED;
                            state_next = S_DONE;
                        end
                        else if (stat.func == FUNC_FREE)
                        begin
                            state_next = S_FR_CHK;
                        end
                        else
                        begin
                            state_next = S_LK_RD;
                        end
                    end
                    FUNC_NONE:
                    begin
                        cmd.op     = OP_ERR_COUNT;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FR_CHK:
            begin
                if (!stat.own_match || !stat.in_use)
                begin
                    cmd.op     = OP_ERR_UNMAPPED;
                    state_next = S_DONE;
                end
                else if (!stat.len_match)
                begin
                    cmd.op     = OP_ERR_COUNT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_FR_INIT;
                    state_next = S_BK0;
                end
            end
            S_LK_RD:
            begin
                cmd.op     = OP_RD_LEN_Q;
                state_next = S_LK_RES;
            end
            S_LK_RES:
            begin
                cmd.op     = OP_RES_LOOKUP;
                state_next = S_DONE;
            end
            // Merge with the span before
            S_BK0:
            begin
                if (stat.bk_ok)
                begin
                    cmd.op     = OP_RD_OWN_PREV;
                    state_next = S_BK1;
                end
                else
                begin
                    state_next = S_FW0;
                end
            end
            S_BK1:
            begin
                cmd.op     = OP_RD_LEN_Q;
                state_next = S_BK2;
            end
            S_BK2:
            begin
                if (stat.merge_ok)
                begin
                    cmd.op     = OP_UL_RD;
                    state_next = S_BK3;
                end
                else
                begin
                    state_next = S_FW0;
                end
            end
            S_BK3:
            begin
                cmd.op     = OP_UL_WR_BK;
                state_next = S_BK0;
            end
            // Merge with the span after
            S_FW0:
            begin
                if (stat.fw_ok)
                begin
                    cmd.op     = OP_RD_OWN_NEXT;
                    state_next = S_FW1;
                end
                else
                begin
                    state_next = S_FR_FIN;
                end
            end
            S_FW1:
            begin
                cmd.op     = OP_RD_LEN_Q;
                state_next = S_FW2;
            end
            S_FW2:
            begin
                if (stat.merge_ok)
                begin
                    cmd.op     = OP_UL_RD;
                    state_next = S_FW3;
                end
                else
                begin
                    state_next = S_FR_FIN;
                end
            end
            S_FW3:
            begin
                cmd.op     = OP_UL_WR_FW;
                state_next = S_FW0;
            end
            S_FR_FIN:
            begin
                cmd.op     = OP_FR_FIN;
                ctx_next   = CTX_FREE;
                state_next = S_PU0;
            end
            // Push onto a free list
            S_PU0:
            begin
                state_next = S_PU1;
            end
            S_PU1:
            begin
                cmd.op     = OP_PU_WR1;
                state_next = S_PU2;
            end
            S_PU2:
            begin
                cmd.op     = OP_PU_WR2;
                state_next = (ctx_reg == CTX_SPLIT) ? S_CUT : S_MAP;
            end
            S_MAP:
            begin
                cmd.op = OP_MAP;
                if (stat.map_last)
                begin
                    state_next = (ctx_reg == CTX_FRESH) ? S_RESCAN : S_RES;
                end
            end
            S_RES:
            begin
                cmd.op     = OP_RES_MAP;
                state_next = S_DONE;
            end
            S_RESCAN:
            begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_SCAN;
            end
            // Search the free lists upward from the requested size
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    state_next = S_TAKE;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_FRESH;
                end
                else
                begin
                    cmd.op = OP_SCAN_NEXT;
                end
            end
            S_TAKE:
            begin
                cmd.op     = OP_TAKE;
                state_next = S_TAKE_UL;
            end
            S_TAKE_UL:
            begin
                cmd.op     = OP_UL_WR;
                state_next = stat.exact ? S_POP_FIN : S_SPLIT;
            end
            S_POP_FIN:
            begin
                cmd.op     = OP_POP_FIN;
                state_next = S_DONE;
            end
            S_SPLIT:
            begin
                cmd.op     = OP_SPLIT;
                ctx_next   = CTX_SPLIT;
                state_next = S_PU0;
            end
            S_CUT:
            begin
                cmd.op     = OP_CUT;
                state_next = S_MAP;
            end
            S_FRESH:
            begin
                if (stat.fresh_ok)
                begin
                    cmd.op     = OP_FRESH;
                    ctx_next   = CTX_FRESH;
                    state_next = S_PU0;
                end
                else
                begin
                    cmd.op     = OP_ERR_OOM;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/psa_dpath.sv
`include "assert_macros.svh"

module psa_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psa_pkg::cmd_t                cmd,
    output psa_pkg::stat_t               stat,
    input  logic                         cfg_wr_en,
    input  logic [psa_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic [1:0]                   func,
    input  logic [psa_pkg::CNT_W-1:0]    page_count,
    input  logic [psa_pkg::PAGE_W-1:0]   page_id,
    output logic [psa_pkg::PAGE_W-1:0]   span_start,
    output logic [psa_pkg::CNT_W-1:0]    span_pages,
    output logic [1:0]                   status,
    output logic                         out_valid,
    input  logic                         out_ready
);
    import psa_pkg::*;

    // Page-indexed stores and list heads
    logic [PAGE_W-1:0] own_mem  [NPAGES];
    logic [INFO_W-1:0] info_mem [NPAGES];
    logic [LINK_W-1:0] prv_mem  [NPAGES];
    logic [LINK_W-1:0] nxt_mem  [NPAGES];
    logic [LINK_W-1:0] head_mem [CLASSES];
    logic [CLASSES-1:0] head_vld_reg;

    logic [PAGE_W-1:0] own_rd_reg;
    logic [INFO_W-1:0] info_rd_reg;
    logic [LINK_W-1:0] prv_rd_reg, nxt_rd_reg, head_rd_reg;
    logic              head_vld_rd_reg;

    // Working registers
    logic [1:0]         func_reg;
    logic [CNT_W-1:0]   cnt_reg, cls_reg, m_cnt_reg, idx_reg;
    logic [PAGE_W-1:0]  pid_reg, s_reg, q_reg, m_base_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LINK_W-1:0]  h_reg;
    logic [LIMIT_W-1:0] fresh_reg, limit_reg;
    logic [PAGE_W-1:0]  res_start_reg, out_start_reg;
    logic [CNT_W-1:0]   res_pages_reg, out_pages_reg;
    logic [1:0]         res_status_reg, out_status_reg;
    logic               out_valid_reg;

    // Memory port controls
    logic [PAGE_W-1:0] own_raddr, info_raddr, link_raddr;
    logic              own_we, info_we, prv_we, nxt_we, head_we, head_vld_wr;
    logic [PAGE_W-1:0] own_waddr, own_wdata, info_waddr, prv_waddr, nxt_waddr;
    logic [INFO_W-1:0] info_wdata;
    logic [LINK_W-1:0] prv_wdata, nxt_wdata, head_wdata, push_head;

    logic [LIMIT_W-1:0] fw_end, lim;
    logic [CNT_W-1:0]   rest;
    logic [PAGE_W-1:0]  map_addr;
    logic               unlink_wr;

    assign fw_end    = {1'b0, s_reg} + {5'd0, len_reg};
    assign lim       = (limit_reg > LIMIT_W'(NPAGES)) ? LIMIT_W'(NPAGES) : limit_reg;
    assign rest      = cls_reg - cnt_reg;
    assign map_addr  = m_base_reg + {5'd0, idx_reg};
    assign push_head = head_vld_rd_reg ? head_rd_reg : NIL_LINK;
    assign unlink_wr = (cmd.op == OP_UL_WR) || (cmd.op == OP_UL_WR_BK)
                    || (cmd.op == OP_UL_WR_FW);

    // Status to the controller
    always_comb
    begin
        stat.func       = func_t'(func_reg);
        stat.cnt_zero   = (cnt_reg == '0);
        stat.pid_mapped = ({1'b0, pid_reg} < fresh_reg);
        stat.own_match  = (own_rd_reg == pid_reg);
        stat.in_use     = info_rd_reg[INFO_W-1];
        stat.len_match  = (info_rd_reg[CNT_W-1:0] == cnt_reg);
        stat.bk_ok      = (s_reg != '0);
        stat.fw_ok      = (fw_end < fresh_reg);
        stat.merge_ok   = !info_rd_reg[INFO_W-1]
                       && (({1'b0, info_rd_reg[CNT_W-1:0]} + len_reg) <= LEN_W'(REGION_PAGES));
        stat.scan_hit   = head_vld_reg[cls_reg];
        stat.scan_last  = (cls_reg == CNT_W'(REGION_PAGES));
        stat.exact      = (cls_reg == cnt_reg);
        stat.fresh_ok   = (({1'b0, fresh_reg} + (LIMIT_W+1)'(REGION_PAGES)) <= {1'b0, lim});
        stat.map_last   = (idx_reg == (m_cnt_reg - CNT_W'(1)));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Decode memory addresses and writes
    always_comb
    begin
        own_raddr   = pid_reg;
        info_raddr  = pid_reg;
        link_raddr  = q_reg;
        own_we      = 1'b0;
        own_waddr   = map_addr;
        own_wdata   = m_base_reg;
        info_we     = 1'b0;
        info_waddr  = q_reg;
        info_wdata  = '0;
        prv_we      = 1'b0;
        prv_waddr   = s_reg;
        prv_wdata   = NIL_LINK;
        nxt_we      = 1'b0;
        nxt_waddr   = s_reg;
        nxt_wdata   = push_head;
        head_we     = 1'b0;
        head_wdata  = {1'b0, s_reg};
        head_vld_wr = 1'b1;

        case (cmd.op)
            OP_RD_OWN_PREV: own_raddr = s_reg - PAGE_W'(1);
            OP_RD_OWN_NEXT: own_raddr = fw_end[PAGE_W-1:0];
            OP_RD_LEN_Q:    info_raddr = own_rd_reg;
            OP_TAKE:        link_raddr = head_rd_reg[PAGE_W-1:0];
            OP_FR_INIT:
            begin
                info_we    = 1'b1;
                info_waddr = pid_reg;
                info_wdata = {1'b0, cnt_reg};
            end
            OP_FR_FIN:
            begin
                info_we    = 1'b1;
                info_waddr = s_reg;
                info_wdata = {1'b0, len_reg[CNT_W-1:0]};
            end
            OP_POP_FIN:
            begin
                info_we    = 1'b1;
                info_wdata = {1'b1, cnt_reg};
            end
            OP_SPLIT:
            begin
                info_we    = 1'b1;
                info_wdata = {1'b0, rest};
            end
            OP_CUT:
            begin
                info_we    = 1'b1;
                info_waddr = m_base_reg;
                info_wdata = {1'b1, m_cnt_reg};
            end
            OP_FRESH:
            begin
                info_we    = 1'b1;
                info_waddr = fresh_reg[PAGE_W-1:0];
                info_wdata = {1'b0, CNT_W'(REGION_PAGES)};
            end
            OP_MAP:         own_we = 1'b1;
            OP_PU_WR1:
            begin
                prv_we  = 1'b1;
                nxt_we  = 1'b1;
                head_we = 1'b1;
            end
            OP_PU_WR2:
            begin
                prv_we    = !h_reg[LINK_W-1];
                prv_waddr = h_reg[PAGE_W-1:0];
                prv_wdata = {1'b0, s_reg};
            end
            default: ;
        endcase

        // Unlink: bypass the node in its list
        if (unlink_wr)
        begin
            if (!prv_rd_reg[LINK_W-1])
            begin
                nxt_we    = 1'b1;
                nxt_waddr = prv_rd_reg[PAGE_W-1:0];
                nxt_wdata = nxt_rd_reg;
            end
            else
            begin
                head_we     = 1'b1;
                head_wdata  = nxt_rd_reg;
                head_vld_wr = !nxt_rd_reg[LINK_W-1];
            end
            prv_we    = !nxt_rd_reg[LINK_W-1];
            prv_waddr = nxt_rd_reg[PAGE_W-1:0];
            prv_wdata = prv_rd_reg;
        end
    end

    // Memories with registered reads
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[own_waddr] <= own_wdata;
        end
        if (info_we)
        begin
            info_mem[info_waddr] <= info_wdata;
        end
        if (prv_we)
        begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (head_we)
        begin
            head_mem[cls_reg] <= head_wdata;
        end
        own_rd_reg      <= own_mem[own_raddr];
        info_rd_reg     <= info_mem[info_raddr];
        prv_rd_reg      <= prv_mem[link_raddr];
        nxt_rd_reg      <= nxt_mem[link_raddr];
        head_rd_reg     <= head_mem[cls_reg];
        head_vld_rd_reg <= head_vld_reg[cls_reg];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= func;
                cnt_reg  <= page_count;
                pid_reg  <= page_id;
            end
            OP_FR_INIT:
            begin
                s_reg   <= pid_reg;
                len_reg <= {1'b0, cnt_reg};
            end
            OP_RD_LEN_Q:  q_reg <= own_rd_reg;
            OP_UL_RD:     cls_reg <= info_rd_reg[CNT_W-1:0];
            OP_UL_WR_BK:
            begin
                len_reg <= len_reg + {1'b0, cls_reg};
                s_reg   <= q_reg;
            end
            OP_UL_WR_FW:  len_reg <= len_reg + {1'b0, cls_reg};
            OP_FR_FIN:
            begin
                cls_reg    <= len_reg[CNT_W-1:0];
                m_base_reg <= s_reg;
                m_cnt_reg  <= len_reg[CNT_W-1:0];
                idx_reg    <= '0;
            end
            OP_PU_WR1:    h_reg <= push_head;
            OP_MAP:       idx_reg <= idx_reg + CNT_W'(1);
            OP_SCAN_INIT: cls_reg <= cnt_reg;
            OP_SCAN_NEXT: cls_reg <= cls_reg + CNT_W'(1);
            OP_TAKE:      q_reg <= head_rd_reg[PAGE_W-1:0];
            OP_SPLIT:
            begin
                s_reg      <= q_reg;
                cls_reg    <= rest;
                m_base_reg <= q_reg + {5'd0, rest};
                m_cnt_reg  <= cnt_reg;
                idx_reg    <= '0;
            end
            OP_FRESH:
            begin
                s_reg      <= fresh_reg[PAGE_W-1:0];
                cls_reg    <= CNT_W'(REGION_PAGES);
                m_base_reg <= fresh_reg[PAGE_W-1:0];
                m_cnt_reg  <= CNT_W'(REGION_PAGES);
                idx_reg    <= '0;
            end
            default: ;
        endcase
    end

    // Result staging and output slot payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ERR_OOM, OP_ERR_UNMAPPED, OP_ERR_COUNT:
            begin
                res_start_reg  <= '0;
                res_pages_reg  <= '0;
                res_status_reg <= (cmd.op == OP_ERR_OOM) ? ST_OOM
                                : (cmd.op == OP_ERR_UNMAPPED) ? ST_UNMAPPED : ST_BAD_COUNT;
            end
            OP_RES_LOOKUP:
            begin
                res_start_reg  <= q_reg;
                res_pages_reg  <= info_rd_reg[CNT_W-1:0];
                res_status_reg <= ST_OK;
            end
            OP_POP_FIN:
            begin
                res_start_reg  <= q_reg;
                res_pages_reg  <= cnt_reg;
                res_status_reg <= ST_OK;
            end
            OP_RES_MAP:
            begin
                res_start_reg  <= m_base_reg;
                res_pages_reg  <= m_cnt_reg;
                res_status_reg <= ST_OK;
            end
            OP_OUT:
            begin
                out_start_reg  <= res_start_reg;
                out_pages_reg  <= res_pages_reg;
                out_status_reg <= res_status_reg;
            end
            default: ;
        endcase
    end

    // Control state: list-valid bits, bump pointer, limit, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg  <= '0;
            fresh_reg     <= '0;
            limit_reg     <= LIMIT_W'(NPAGES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_we)
            begin
                head_vld_reg[cls_reg] <= head_vld_wr;
            end
            if (cmd.op == OP_FRESH)
            begin
                fresh_reg <= fresh_reg + LIMIT_W'(REGION_PAGES);
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign span_start = out_start_reg;
    assign span_pages = out_pages_reg;
    assign status     = out_status_reg;
    assign out_valid  = out_valid_reg;

    `ASSERT_IMP(a_fresh_bound, clk, rst_n, 1'b1, fresh_reg <= LIMIT_W'(NPAGES))
    `ASSERT_IMP(a_out_slot_free, clk, rst_n, cmd.op == OP_OUT, !out_valid_reg || out_ready)
    `ASSERT_IMP(a_map_in_pool, clk, rst_n, cmd.op == OP_MAP, {1'b0, map_addr} < fresh_reg)
    `ASSERT_NXT(a_fresh_step, clk, rst_n, cmd.op == OP_FRESH, fresh_reg == $past(fresh_reg) + LIMIT_W'(REGION_PAGES))

endmodule

FILE: rtl/page_span_allocator_core.sv
// Page span allocator: one transaction at a time (alloc, free or lookup), one result per
// transaction. An alloc scans the size classes upward from the requested size, up to class
// 127, and pops the first span it finds. A larger span is split: the rest is pushed back on
// a free list and each page taken is mapped. If no list holds a span, a fresh region is
// carved, pushed, mapped page by page and scanned again. A free merges with the spans before
// and after it while the result stays within a class, then pushes the merged span and maps
// each of its pages. A lookup reads the owner and length of a page. A finished result waits
// in an output register, so a new transaction can be accepted while the previous result is
// still held. No clearing pass after reset is needed.
module page_span_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [psa_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [psa_pkg::CNT_W-1:0]    page_count,
    input  logic [psa_pkg::PAGE_W-1:0]   page_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [psa_pkg::PAGE_W-1:0]   span_start,
    output logic [psa_pkg::CNT_W-1:0]    span_pages,
    output logic [1:0]                   status
);
    import psa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    psa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Memories and working registers
    psa_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (func),
        .page_count  (page_count),
        .page_id     (page_id),
        .span_start  (span_start),
        .span_pages  (span_pages),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

FILE: sim/psa_checker.sv
module psa_checker
    import psa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         func,
    input  logic [CNT_W-1:0]   page_count,
    input  logic [PAGE_W-1:0]  page_id,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [PAGE_W-1:0]  span_start,
    input  logic [CNT_W-1:0]   span_pages,
    input  logic [1:0]         status,
    output int                 mismatch_count,
    output int                 outstanding
);

    typedef struct {
        logic [PAGE_W-1:0] start;
        logic [CNT_W-1:0]  pages;
        status_t           st;
    } span_result_t;

    // Shadow copy of the allocator state
    logic [PAGE_W-1:0]  owner_of   [NPAGES];
    bit                 mapped     [NPAGES];
    logic [CNT_W-1:0]   length_at  [NPAGES];
    bit                 busy       [NPAGES];
    logic [LINK_W-1:0]  next_link  [NPAGES];
    logic [LINK_W-1:0]  prev_link  [NPAGES];
    logic [LINK_W-1:0]  class_head [CLASSES];
    int                 bump_page;
    int                 pool_limit;
    span_result_t       expected_spans [$];

    task automatic clear_shadow();
        for (int i = 0; i < NPAGES; i++)
        begin
            owner_of[i] = '0;
            mapped[i] = 0;
            length_at[i] = '0;
            busy[i] = 0;
            next_link[i] = NIL_LINK;
            prev_link[i] = NIL_LINK;
        end
        for (int i = 0; i < CLASSES; i++)
            class_head[i] = NIL_LINK;
        bump_page = 0;
        pool_limit = NPAGES;
        expected_spans.delete();
    endtask

    task automatic list_push(int len, int s);
        int h;
        h = class_head[len];
        prev_link[s] = NIL_LINK;
        next_link[s] = LINK_W'(h);
        if (h < NPAGES)
            prev_link[h] = LINK_W'(s);
        class_head[len] = LINK_W'(s);
    endtask

    task automatic list_unlink(int len, int s);
        int p;
        int n;
        p = prev_link[s];
        n = next_link[s];
        if (p < NPAGES)
            next_link[p] = LINK_W'(n);
        else
            class_head[len] = LINK_W'(n);
        if (n < NPAGES)
            prev_link[n] = LINK_W'(p);
    endtask

    task automatic map_pages(int s, int len);
        for (int i = 0; i < len; i++)
        begin
            if (s + i < NPAGES)
            begin
                owner_of[s + i] = PAGE_W'(s);
                mapped[s + i] = 1;
            end
        end
    endtask

    // Pop an exact fit, else split the first longer span from its tail
    task automatic take_span(int n, output bit found, output int start);
        int s;
        int rest;
        found = 0;
        start = 0;
        s = class_head[n];
        if (s < NPAGES)
        begin
            list_unlink(n, s);
            busy[s] = 1;
            start = s;
            found = 1;
            return;
        end
        for (int i = n + 1; i < CLASSES; i++)
        begin
            s = class_head[i];
            if (s < NPAGES)
            begin
                list_unlink(i, s);
                rest = i - n;
                length_at[s] = CNT_W'(rest);
                list_push(rest, s);
                length_at[s + rest] = CNT_W'(n);
                busy[s + rest] = 1;
                map_pages(s + rest, n);
                start = s + rest;
                found = 1;
                return;
            end
        end
    endtask

    task automatic predict_span(input func_t f, input int cnt, input int pid,
                                output span_result_t r);
        bit found;
        int s;
        int len;
        int q;
        int lim;
        r.start = '0;
        r.pages = '0;
        r.st = ST_OK;
        case (f)
            FUNC_ALLOC:
            begin
                lim = (pool_limit > NPAGES) ? NPAGES : pool_limit;
                if (cnt == 0)
                    r.st = ST_BAD_COUNT;
                else
                begin
                    take_span(cnt, found, s);
                    if (!found && bump_page + REGION_PAGES <= lim)
                    begin
                        // carve a fresh region, then take from it like any other span
                        length_at[bump_page] = CNT_W'(REGION_PAGES);
                        busy[bump_page] = 0;
                        map_pages(bump_page, REGION_PAGES);
                        list_push(REGION_PAGES, bump_page);
                        bump_page += REGION_PAGES;
                        take_span(cnt, found, s);
                    end
                    if (found)
                    begin
                        r.start = PAGE_W'(s);
                        r.pages = CNT_W'(cnt);
                    end
                    else
                        r.st = ST_OOM;
                end
            end
            FUNC_FREE:
            begin
                if (!mapped[pid] || owner_of[pid] != pid || !busy[pid])
                    r.st = ST_UNMAPPED;
                else if (length_at[pid] != cnt)
                    r.st = ST_BAD_COUNT;
                else
                begin
                    s = pid;
                    len = cnt;
                    busy[s] = 0;
                    // merge backward, then forward, while the span stays within a class
                    while (s > 0 && mapped[s - 1])
                    begin
                        q = owner_of[s - 1];
                        if (busy[q] || length_at[q] + len > CLASSES - 1)
                            break;
                        list_unlink(length_at[q], q);
                        len += length_at[q];
                        s = q;
                    end
                    while (s + len < NPAGES && mapped[s + len])
                    begin
                        q = owner_of[s + len];
                        if (busy[q] || length_at[q] + len > CLASSES - 1)
                            break;
                        list_unlink(length_at[q], q);
                        len += length_at[q];
                    end
                    length_at[s] = CNT_W'(len);
                    busy[s] = 0;
                    map_pages(s, len);
                    list_push(len, s);
                    r.start = PAGE_W'(s);
                    r.pages = CNT_W'(len);
                end
            end
            FUNC_LOOKUP:
            begin
                if (mapped[pid])
                begin
                    r.start = owner_of[pid];
                    r.pages = length_at[owner_of[pid]];
                end
                else
                    r.st = ST_UNMAPPED;
            end
            default:
                r.st = ST_BAD_COUNT;
        endcase
    endtask

    task automatic report_mismatch(string field_name, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field_name,
                 got, want);
        mismatch_count++;
    endtask

    initial
    begin
        mismatch_count = 0;
        clear_shadow();
    end

    assign outstanding = expected_spans.size();

    // Track config writes, predict each accepted request, check each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        span_result_t r;
        span_result_t want;
        if (!rst_n)
            clear_shadow();
        else
        begin
            if (cfg_wr_en)
                pool_limit = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                predict_span(func_t'(func), page_count, page_id, r);
                expected_spans.push_back(r);
            end
            if (out_valid && out_ready)
            begin
                if (expected_spans.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = expected_spans.pop_front();
                    if (span_start !== want.start)
                        report_mismatch("span_start", span_start, want.start);
                    if (span_pages !== want.pages)
                        report_mismatch("span_pages", span_pages, want.pages);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                end
            end
        end
    end

endmodule

FILE: sim/tb_page_span_allocator_core.sv
module tb_page_span_allocator_core;
    import psa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 600;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [CNT_W-1:0]   page_count;
    logic [PAGE_W-1:0]  page_id;
    logic               out_valid;
    logic               out_ready;
    logic [PAGE_W-1:0]  span_start;
    logic [CNT_W-1:0]   span_pages;
    logic [1:0]         status;
    int                 mismatch_count;
    int                 outstanding;

    int  cycle_count;
    bit  calm_rx;
    bit  calm_tx;
    bit  hold_rx;
    bit  hold_req;
    int  inflight_funcs [$];
    int  live_start [$];
    int  live_len [$];
    int  freed_start [$];
    int  freed_len [$];

    page_span_allocator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .page_count  (page_count),
        .page_id     (page_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .span_start  (span_start),
        .span_pages  (span_pages),
        .status      (status)
    );

    psa_checker span_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .page_count     (page_count),
        .page_id        (page_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .span_start     (span_start),
        .span_pages     (span_pages),
        .status         (status),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_page_span_allocator_core: done, errors");
            $finish;
        end
    end

    // Receiver: random backpressure, or a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n || hold_rx)
            out_ready <= 1'b0;
        else
            out_ready <= calm_rx || ($urandom_range(99) >= 16);
    end

    initial
    begin
        hold_rx = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_rx = 1;
                repeat (400) @(negedge clk);
                hold_rx = 0;
                hold_req = 0;
            end
        end
    end

    // Remember which transactions are in flight and which spans are held
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                inflight_funcs.push_back(func);
            if (out_valid && out_ready && inflight_funcs.size() != 0)
            begin
                if (inflight_funcs.pop_front() == FUNC_ALLOC && status == ST_OK)
                begin
                    live_start.push_back(span_start);
                    live_len.push_back(span_pages);
                end
            end
        end
    end

    task automatic send_item(func_t f, int cnt, int pid);
        int gap;
        if (!calm_tx && $urandom_range(99) < 16)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func <= f;
        page_count <= CNT_W'(cnt);
        page_id <= PAGE_W'(pid);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every result has drained
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (inflight_funcs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= LIMIT_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random(int n_items);
        int pick;
        int idx;
        int cnt;
        int s;
        int len;
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    cnt = $urandom_range(1, 16);
                else if (pick < 90)
                    cnt = $urandom_range(17, 126);
                else if (pick < 95)
                    cnt = 127;
                else
                    cnt = 0;
                send_item(FUNC_ALLOC, cnt, $urandom_range(NPAGES - 1));
            end
            else if (pick < 80 && live_start.size() != 0)
            begin
                idx = $urandom_range(live_start.size() - 1);
                s = live_start[idx];
                len = live_len[idx];
                pick = $urandom_range(99);
                if (pick < 80)
                begin
                    // well-formed release of a held span
                    live_start.delete(idx);
                    live_len.delete(idx);
                    freed_start.push_back(s);
                    freed_len.push_back(len);
                    if (freed_start.size() > 8)
                    begin
                        void'(freed_start.pop_front());
                        void'(freed_len.pop_front());
                    end
                    send_item(FUNC_FREE, len, s);
                end
                else if (pick < 87)
                    send_item(FUNC_FREE, (len + $urandom_range(1, 126)) % 128, s);
                else if (pick < 94)
                    send_item(FUNC_FREE, len, s + $urandom_range(0, len - 1));
                else if (freed_start.size() != 0)
                    send_item(FUNC_FREE, freed_len[0], freed_start[0]);
                else
                    send_item(FUNC_FREE, $urandom_range(127), $urandom_range(NPAGES - 1));
            end
            else if (pick < 97)
            begin
                if (live_start.size() != 0 && $urandom_range(1) == 0)
                begin
                    idx = $urandom_range(live_start.size() - 1);
                    send_item(FUNC_LOOKUP, $urandom_range(127),
                              live_start[idx] + $urandom_range(0, live_len[idx] - 1));
                end
                else
                    send_item(FUNC_LOOKUP, $urandom_range(127), $urandom_range(NPAGES - 1));
            end
            else
                send_item(FUNC_NONE, $urandom_range(127), $urandom_range(NPAGES - 1));
            if (k == n_items / 2 && n_items > 200)
                hold_req = 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        func = FUNC_ALLOC;
        page_count = '0;
        page_id = '0;
        out_ready = 1'b0;
        calm_rx = 0;
        calm_tx = 0;
        hold_req = 0;
        cycle_count = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: errors on an empty pool, fresh region, split, merge up to the cap
        send_item(FUNC_LOOKUP, 0, 0);
        send_item(FUNC_LOOKUP, 127, NPAGES - 1);
        send_item(FUNC_ALLOC, 0, 0);
        send_item(FUNC_NONE, 127, NPAGES - 1);
        send_item(FUNC_FREE, 1, NPAGES - 1);
        send_item(FUNC_ALLOC, 1, 0);
        send_item(FUNC_ALLOC, 127, 0);
        send_item(FUNC_ALLOC, 5, 0);
        send_item(FUNC_FREE, 1, 126);
        send_item(FUNC_FREE, 5, 121);
        send_item(FUNC_FREE, 5, 121);
        send_item(FUNC_FREE, 5, 127);
        send_item(FUNC_FREE, 127, 127);
        send_item(FUNC_LOOKUP, 0, 200);
        send_item(FUNC_LOOKUP, 0, 254);
        send_item(FUNC_ALLOC, 126, 0);
        send_item(FUNC_FREE, 1, 130);
        send_item(FUNC_LOOKUP, 0, 129);
        send_item(FUNC_ALLOC, 1, 0);
        drain();
        live_start.delete();
        live_len.delete();

        // Random phases across pool limits, including the extremes
        calm_rx = 1;
        calm_tx = 1;
        send_random(250);
        drain();
        calm_rx = 0;
        calm_tx = 0;
        send_random(300);
        drain();
        write_limit(381);
        send_random(200);
        drain();
        write_limit((1 << LIMIT_W) - 1);
        send_random(300);
        drain();
        write_limit(0);
        send_random(150);
        drain();
        write_limit(NPAGES);
        send_random(200);
        drain();

        if (mismatch_count == 0 && outstanding == 0)
            $display("tb_page_span_allocator_core: done, clean");
        else
            $display("tb_page_span_allocator_core: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/psa_pkg.sv
rtl/psa_ctrl.sv
rtl/psa_dpath.sv
rtl/page_span_allocator_core.sv
sim/psa_checker.sv
sim/tb_page_span_allocator_core.sv
